// ----- rtl/b32le_pkg.sv -----
package b32le_pkg;

  localparam int unsigned LABEL_MAX_DEF = 50;
  localparam int unsigned DIGIT_W       = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TOK_DIGITS    = 3;

  localparam logic [BYTE_W-1:0] DIGIT_CHARS [32] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h62, 8'h63, 8'h64, 8'h66, 8'h67, 8'h68,
    8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h70, 8'h71, 8'h72,
    8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
  };

  typedef struct packed {
    logic [TOK_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [1:0]                         ndig;
    logic                               eom;
  } tok_t;

  function automatic logic [BYTE_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

// ----- rtl/b32le_in_if.sv -----
interface b32le_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ----- rtl/b32le_out_if.sv -----
interface b32le_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_length;
  logic       run_last;

  modport source (output valid, output out_byte, output is_length, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_length, input run_last,
                  output ready);
endinterface

// ----- rtl/b32le_ram.sv -----
module b32le_ram
  import b32le_pkg::*;
#(
  parameter int unsigned WIDTH = DIGIT_W,
  parameter int unsigned DEPTH = LABEL_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/b32le_front.sv -----
module b32le_front
  import b32le_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b32le_in_if.sink   in_i,
  output logic       tok_valid_o,
  output tok_t       tok_o,
  input  logic       tok_ready_i
);

  logic [3:0]  res_bits_q, res_bits_d;
  logic [2:0]  res_cnt_q, res_cnt_d;
  logic [14:0] v;
  logic [3:0]  bits;
  logic        two;
  logic [2:0]  left;
  logic        accept;

  assign accept = in_i.valid && tok_ready_i;
  assign in_i.ready = tok_ready_i;
  assign tok_valid_o = in_i.valid;

  assign v    = 15'(res_bits_q) | (15'(in_i.data_byte) << res_cnt_q);
  assign bits = 4'(res_cnt_q) + 4'd8;
  assign two  = bits >= 4'd10;
  assign left = two ? 3'(bits - 4'd10) : 3'(bits - 4'd5);

  always_comb begin
    tok_o.digits[0] = v[4:0];
    tok_o.digits[1] = v[9:5];
    tok_o.digits[2] = v[14:10];
    tok_o.ndig      = 2'd1 + 2'(two) + 2'(in_i.end_of_message && (left != 3'd0));
    tok_o.eom       = in_i.end_of_message;
    if (in_i.end_of_message) begin
      res_bits_d = '0;
      res_cnt_d  = '0;
    end else begin
      res_bits_d = two ? v[13:10] : v[8:5];
      res_cnt_d  = left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= '0;
      res_cnt_q  <= '0;
    end else if (accept) begin
      res_bits_q <= res_bits_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

endmodule

// ----- rtl/b32le_queue.sv -----
module b32le_queue
  import b32le_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  tok_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output tok_t rd_data_o
);

  tok_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       wr, rd;

  assign wr_ready_o = count_q != 2'd2;
  assign rd_valid_o = count_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_ready_i && rd_valid_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (wr) begin
        wptr_q <= !wptr_q;
      end
      if (rd) begin
        rptr_q <= !rptr_q;
      end
      case ({wr, rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/b32le_back.sv -----
module b32le_back
  import b32le_pkg::*;
#(
  parameter int unsigned LABEL_MAX = LABEL_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  input  tok_t       tok_i,
  output logic       tok_ready_o,
  b32le_out_if.source out_o
);

  localparam int unsigned FW = $clog2(LABEL_MAX + 1);
  localparam int unsigned AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  typedef enum logic [1:0] {S_PUSH, S_LEN, S_CHAR} state_e;

  state_e        state_q;
  logic [FW-1:0] fill_q, len_q, cnt_q;
  logic [1:0]    idx_q;
  logic          last_q, resume_q;
  logic          out_valid_q, is_length_q, run_last_q;
  logic [7:0]    out_byte_q;

  logic [DIGIT_W-1:0] cur_dig, rdata;
  logic [1:0]         rem;
  logic [FW-1:0]      fill_inc, cnt_inc;
  logic               hit_max, more_emit, push, out_free, char_end;
  logic               out_load;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;

  assign cur_dig   = tok_i.digits[idx_q];
  assign rem       = tok_i.ndig - 2'd1 - idx_q;
  assign fill_inc  = fill_q + FW'(1);
  assign cnt_inc   = cnt_q + FW'(1);
  assign hit_max   = fill_inc == FW'(LABEL_MAX);
  assign more_emit = (rem != 2'd0) && (tok_i.eom || (FW'(rem) >= FW'(LABEL_MAX)));
  assign push      = (state_q == S_PUSH) && tok_valid_i;
  assign out_free  = !out_valid_q || out_o.ready;
  assign char_end  = cnt_q == (len_q - FW'(1));
  assign out_load  = out_free && ((state_q == S_LEN) || (state_q == S_CHAR));

  assign ram_re    = out_free && ((state_q == S_LEN) || ((state_q == S_CHAR) && !char_end));
  assign ram_raddr = (state_q == S_LEN) ? '0 : cnt_inc[AW-1:0];

  always_comb begin
    case (state_q)
      S_PUSH:  tok_ready_o = push && !hit_max && (rem == 2'd0) && !tok_i.eom;
      S_CHAR:  tok_ready_o = out_free && char_end && !resume_q;
      default: tok_ready_o = 1'b0;
    endcase
  end

  b32le_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (LABEL_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (cur_dig),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.is_length = is_length_q;
  assign out_o.run_last  = run_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PUSH;
      fill_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      resume_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      is_length_q <= 1'b0;
      run_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_PUSH: begin
          if (push) begin
            if (hit_max || ((rem == 2'd0) && tok_i.eom)) begin
              len_q    <= fill_inc;
              last_q   <= !more_emit;
              resume_q <= rem != 2'd0;
              fill_q   <= '0;
              state_q  <= S_LEN;
            end else begin
              fill_q <= fill_inc;
              idx_q  <= (rem == 2'd0) ? 2'd0 : idx_q + 2'd1;
            end
          end
        end
        S_LEN: begin
          if (out_free) begin
            out_byte_q  <= 8'(len_q);
            is_length_q <= 1'b1;
            run_last_q  <= 1'b0;
            cnt_q       <= '0;
            state_q     <= S_CHAR;
          end
        end
        S_CHAR: begin
          if (out_free) begin
            out_byte_q  <= digit_char(rdata);
            is_length_q <= 1'b0;
            run_last_q  <= last_q && char_end;
            if (char_end) begin
              state_q <= S_PUSH;
              idx_q   <= resume_q ? idx_q + 2'd1 : 2'd0;
            end else begin
              cnt_q <= cnt_inc;
            end
          end
        end
        default: state_q <= S_PUSH;
      endcase
    end
  end

endmodule

// ----- rtl/base32_label_encoder.sv -----
// Base32 label encoder: bytes enter on in_i, are packed little-endian into 5-bit
// digits and leave on out_o as length-prefixed labels of up to LABEL_MAX digit
// characters; end_of_message closes the message and flushes the partial label.
// The front end converts a byte into its one to three digits in the cycle it
// is accepted and hands them through a two-entry queue to the back end. The
// back end stores one digit per cycle in the label RAM while no flush is
// under way; a byte yields one or two digits, two or three on a final byte
// with leftover bits. A flush emits the length byte, then the characters read
// back from the label RAM at one a cycle while out_o is ready; the queue takes
// one more byte while a flush is under way. No start-up clearing pass is needed.
module base32_label_encoder
  import b32le_pkg::*;
#(
  parameter int unsigned LABEL_MAX = LABEL_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  b32le_in_if.sink     in_i,
  b32le_out_if.source  out_o
);

  logic tf_valid, tf_ready;
  tok_t tf_tok;
  logic tb_valid, tb_ready;
  tok_t tb_tok;

  b32le_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .tok_valid_o (tf_valid),
    .tok_o       (tf_tok),
    .tok_ready_i (tf_ready)
  );

  b32le_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (tf_valid),
    .wr_ready_o (tf_ready),
    .wr_data_i  (tf_tok),
    .rd_valid_o (tb_valid),
    .rd_ready_i (tb_ready),
    .rd_data_o  (tb_tok)
  );

  b32le_back #(
    .LABEL_MAX (LABEL_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tb_valid),
    .tok_i       (tb_tok),
    .tok_ready_o (tb_ready),
    .out_o       (out_o)
  );

endmodule
